/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRRE_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/srre_pkg.sv */
// Types and constants shared by the square region rotate engine.
package srre_pkg;

  localparam int VAL_W   = 13;  // cell value width
  localparam int COORD_W = 7;   // row / column counter width
  localparam int SIZE_W  = 7;   // matrix_size register width

  typedef enum logic [1:0] {
    CMD_FILL   = 2'd0,
    CMD_ROTATE = 2'd1,
    CMD_READ   = 2'd2
  } srre_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_COPY,
    ST_GAP,
    ST_BACK,
    ST_RD_ISSUE,
    ST_RD_DATA,
    ST_RESULT
  } srre_state_e;

  // Enables towards the two memories.
  typedef struct packed {
    logic cell_we;
    logic cell_re;
    logic scr_we;
    logic scr_re;
  } srre_mem_ctl_t;

endpackage

/* src/srre_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
module srre_ram #(
  parameter int DEPTH = 4096,
  parameter int DW    = 13,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/srre_ctrl.sv */
// Command sequencer: walks fill / rotate / read over the cell and scratch memories.
module srre_ctrl #(
  parameter int MAX_SIZE = 64,
  localparam int AW      = $clog2(MAX_SIZE * MAX_SIZE)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command request
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    in_cmd_i,
  input  logic [5:0]                    in_row_i,
  input  logic [5:0]                    in_col_i,
  input  logic [4:0]                    in_radius_i,
  input  logic                          in_ccw_i,
  input  logic [srre_pkg::SIZE_W-1:0]   size_i,
  // memories
  output srre_pkg::srre_mem_ctl_t       mem_ctl_o,
  output logic [AW-1:0]                 cell_waddr_o,
  output logic [srre_pkg::VAL_W-1:0]    cell_wdata_o,
  output logic [AW-1:0]                 cell_raddr_o,
  input  logic [srre_pkg::VAL_W-1:0]    cell_rdata_i,
  output logic [AW-1:0]                 scr_waddr_o,
  output logic [srre_pkg::VAL_W-1:0]    scr_wdata_o,
  output logic [AW-1:0]                 scr_raddr_o,
  input  logic [srre_pkg::VAL_W-1:0]    scr_rdata_i,
  // result
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [srre_pkg::VAL_W-1:0]    res_value_o,
  output logic                          res_err_o
);

  localparam int SW = $clog2(MAX_SIZE + 1);
  localparam int CW = (SW > 8) ? SW : 8;
  localparam int KW = srre_pkg::COORD_W;
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_SIZE);

  function automatic logic [AW-1:0] cell_addr(input logic [KW-1:0] row,
                                               input logic [KW-1:0] col);
    return AW'(AW'(row) * ROW_STRIDE + AW'(col));
  endfunction

  srre_pkg::srre_state_e state_q, state_d;

  logic [KW-1:0] i_q, i_d, j_q, j_d, tr_q, tr_d, tc_q, tc_d;
  logic [KW-1:0] lo_i_q, lo_i_d, hi_i_q, hi_i_d, lo_j_q, lo_j_d, hi_j_q, hi_j_d;
  logic          ccw_q, ccw_d;
  logic [srre_pkg::VAL_W-1:0] val_q, val_d;
  logic          err_q, err_d;
  logic          pend_q, pend_d, pend_scr_q, pend_scr_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;

  // effective size and range checks on the incoming command
  logic [CW-1:0] size_ext, n_eff, x_ext, y_ext, r_ext;
  logic          rot_bad, rd_bad;
  logic [KW-1:0] x_lo, x_hi, y_lo, y_hi, n_last;

  assign size_ext = CW'(size_i);
  assign n_eff    = (size_i == '0) ? CW'(1)
                  : ((size_ext > CW'(MAX_SIZE)) ? CW'(MAX_SIZE) : size_ext);
  assign x_ext    = CW'(in_row_i);
  assign y_ext    = CW'(in_col_i);
  assign r_ext    = CW'(in_radius_i);
  assign rot_bad  = (x_ext < r_ext) || (x_ext + r_ext >= n_eff)
                 || (y_ext < r_ext) || (y_ext + r_ext >= n_eff);
  assign rd_bad   = (x_ext >= n_eff) || (y_ext >= n_eff);
  assign x_lo     = KW'(in_row_i) - KW'(in_radius_i);
  assign x_hi     = KW'(in_row_i) + KW'(in_radius_i);
  assign y_lo     = KW'(in_col_i) - KW'(in_radius_i);
  assign y_hi     = KW'(in_col_i) + KW'(in_radius_i);
  assign n_last   = KW'(n_eff - CW'(1));

  // raster walk over [lo_i..hi_i] x [lo_j..hi_j]
  logic          row_end, walk_last;
  logic [KW-1:0] i_step, j_step, tr_step, tc_step;
  logic [AW-1:0] ij_addr, tgt_addr;

  assign row_end   = (j_q == hi_j_q);
  assign walk_last = row_end && (i_q == hi_i_q);
  assign i_step    = row_end ? KW'(i_q + KW'(1)) : i_q;
  assign j_step    = row_end ? lo_j_q : KW'(j_q + KW'(1));
  // rotated target: clockwise runs rows up along j, columns down along i
  always_comb begin
    if (!ccw_q) begin
      tr_step = row_end ? lo_i_q : KW'(tr_q + KW'(1));
      tc_step = row_end ? KW'(tc_q - KW'(1)) : tc_q;
    end else begin
      tr_step = row_end ? hi_i_q : KW'(tr_q - KW'(1));
      tc_step = row_end ? KW'(tc_q + KW'(1)) : tc_q;
    end
  end
  assign ij_addr  = cell_addr(i_q, j_q);
  assign tgt_addr = cell_addr(tr_q, tc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srre_pkg::ST_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q         <= i_d;
    j_q         <= j_d;
    tr_q        <= tr_d;
    tc_q        <= tc_d;
    lo_i_q      <= lo_i_d;
    hi_i_q      <= hi_i_d;
    lo_j_q      <= lo_j_d;
    hi_j_q      <= hi_j_d;
    ccw_q       <= ccw_d;
    val_q       <= val_d;
    err_q       <= err_d;
    pend_scr_q  <= pend_scr_d;
    pend_addr_q <= pend_addr_d;
  end

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    tr_d        = tr_q;
    tc_d        = tc_q;
    lo_i_d      = lo_i_q;
    hi_i_d      = hi_i_q;
    lo_j_d      = lo_j_q;
    hi_j_d      = hi_j_q;
    ccw_d       = ccw_q;
    val_d       = val_q;
    err_d       = err_q;
    pend_d      = 1'b0;
    pend_scr_d  = pend_scr_q;
    pend_addr_d = pend_addr_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_ctl_o   = '0;

    // write of the previous cycle's read (copy or copy-back)
    mem_ctl_o.scr_we  = pend_q && pend_scr_q;
    mem_ctl_o.cell_we = pend_q && !pend_scr_q;

    unique case (state_q)
      srre_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          val_d = '0;
          err_d = 1'b0;
          ccw_d = in_ccw_i;
          unique case (srre_pkg::srre_cmd_e'(in_cmd_i))
            srre_pkg::CMD_FILL: begin
              lo_i_d  = '0;
              lo_j_d  = '0;
              hi_i_d  = n_last;
              hi_j_d  = n_last;
              i_d     = '0;
              j_d     = '0;
              val_d   = srre_pkg::VAL_W'(1);
              state_d = srre_pkg::ST_FILL;
            end
            srre_pkg::CMD_ROTATE: begin
              if (rot_bad) begin
                err_d   = 1'b1;
                state_d = srre_pkg::ST_RESULT;
              end else begin
                lo_i_d  = x_lo;
                hi_i_d  = x_hi;
                lo_j_d  = y_lo;
                hi_j_d  = y_hi;
                i_d     = x_lo;
                j_d     = y_lo;
                tr_d    = in_ccw_i ? x_hi : x_lo;
                tc_d    = in_ccw_i ? y_lo : y_hi;
                state_d = srre_pkg::ST_COPY;
              end
            end
            srre_pkg::CMD_READ: begin
              if (rd_bad) begin
                err_d   = 1'b1;
                state_d = srre_pkg::ST_RESULT;
              end else begin
                i_d     = KW'(in_row_i);
                j_d     = KW'(in_col_i);
                state_d = srre_pkg::ST_RD_ISSUE;
              end
            end
            default: begin
              state_d = srre_pkg::ST_RESULT;
            end
          endcase
        end
      end
      srre_pkg::ST_FILL: begin
        mem_ctl_o.cell_we = 1'b1;
        i_d   = i_step;
        j_d   = j_step;
        val_d = srre_pkg::VAL_W'(val_q + srre_pkg::VAL_W'(1));
        if (walk_last) begin
          val_d   = '0;
          state_d = srre_pkg::ST_RESULT;
        end
      end
      srre_pkg::ST_COPY: begin
        mem_ctl_o.cell_re = 1'b1;
        pend_d      = 1'b1;
        pend_scr_d  = 1'b1;
        pend_addr_d = tgt_addr;
        i_d  = i_step;
        j_d  = j_step;
        tr_d = tr_step;
        tc_d = tc_step;
        if (walk_last) begin
          i_d     = lo_i_q;
          j_d     = lo_j_q;
          state_d = srre_pkg::ST_GAP;
        end
      end
      srre_pkg::ST_GAP: begin
        // last scratch write lands here, before the copy-back reads it
        state_d = srre_pkg::ST_BACK;
      end
      srre_pkg::ST_BACK: begin
        mem_ctl_o.scr_re = 1'b1;
        pend_d      = 1'b1;
        pend_scr_d  = 1'b0;
        pend_addr_d = ij_addr;
        i_d = i_step;
        j_d = j_step;
        if (walk_last) begin
          state_d = srre_pkg::ST_RESULT;
        end
      end
      srre_pkg::ST_RD_ISSUE: begin
        mem_ctl_o.cell_re = 1'b1;
        state_d = srre_pkg::ST_RD_DATA;
      end
      srre_pkg::ST_RD_DATA: begin
        val_d   = cell_rdata_i;
        state_d = srre_pkg::ST_RESULT;
      end
      srre_pkg::ST_RESULT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = srre_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = srre_pkg::ST_IDLE;
      end
    endcase
  end

  assign cell_waddr_o = (state_q == srre_pkg::ST_FILL) ? ij_addr : pend_addr_q;
  assign cell_wdata_o = (state_q == srre_pkg::ST_FILL) ? val_q : scr_rdata_i;
  assign cell_raddr_o = ij_addr;
  assign scr_waddr_o  = pend_addr_q;
  assign scr_wdata_o  = cell_rdata_i;
  assign scr_raddr_o  = ij_addr;
  assign res_value_o  = val_q;
  assign res_err_o    = err_q;

endmodule

/* src/square_region_rotate_engine_core.sv */
// Top level of the square region rotate engine: memories, sequencer, result register.
//
// Holds a MAX_SIZE x MAX_SIZE matrix of 13-bit cells in a synchronous RAM
// (row-major, stride MAX_SIZE) plus a scratch RAM of the same shape. One
// request on the slave stream is one command; each yields exactly one result
// on the master stream. Commands are handled one at a time; the slave side
// takes the next request once the previous result has moved into the output
// register, which may still be waiting on the sink. A fill writes the n x n
// matrix one cell a cycle (n = matrix_size clamped to 1..MAX_SIZE); a rotate
// reads the square of side 2r+1 from the cell RAM into its rotated place in
// scratch, then copies it back, one cell a cycle, bounded by the single read
// port of each RAM; a read does one registered RAM read; a range error or
// unknown command goes straight to the result.
// Rotate and read outside the matrix are ignored and flagged in tuser.
// Cells not yet written by a fill or rotate read back undefined. There is no
// clearing pass after reset. matrix_size is written through the cfg channel,
// always ready, and must only change while no command is in flight.
module square_region_rotate_engine_core #(
  parameter int MAX_SIZE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: matrix_size
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  // command stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // center_row[5:0], center_col[11:6],
                                       // radius[16:12], counterclockwise[17], zero
  input  logic [1:0]  s_axis_tuser_i,  // cmd[1:0]
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // cell_value[12:0], zero
  output logic [0:0]  m_axis_tuser_o   // range_error[0]
);

  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int VW    = srre_pkg::VAL_W;

  // matrix_size register
  logic [srre_pkg::SIZE_W-1:0] size_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= srre_pkg::SIZE_W'(64);
    end else if (cfg_valid_i) begin
      size_q <= cfg_data_i;
    end
  end

  srre_pkg::srre_mem_ctl_t mem_ctl;
  logic [AW-1:0] cell_waddr, cell_raddr, scr_waddr, scr_raddr;
  logic [VW-1:0] cell_wdata, cell_rdata, scr_wdata, scr_rdata;
  logic          res_valid, res_ready, res_err;
  logic [VW-1:0] res_value;

  srre_ctrl #(
    .MAX_SIZE (MAX_SIZE)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_cmd_i     (s_axis_tuser_i),
    .in_row_i     (s_axis_tdata_i[5:0]),
    .in_col_i     (s_axis_tdata_i[11:6]),
    .in_radius_i  (s_axis_tdata_i[16:12]),
    .in_ccw_i     (s_axis_tdata_i[17]),
    .size_i       (size_q),
    .mem_ctl_o    (mem_ctl),
    .cell_waddr_o (cell_waddr),
    .cell_wdata_o (cell_wdata),
    .cell_raddr_o (cell_raddr),
    .cell_rdata_i (cell_rdata),
    .scr_waddr_o  (scr_waddr),
    .scr_wdata_o  (scr_wdata),
    .scr_raddr_o  (scr_raddr),
    .scr_rdata_i  (scr_rdata),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_value_o  (res_value),
    .res_err_o    (res_err)
  );

  // matrix cells
  srre_ram #(
    .DEPTH (DEPTH),
    .DW    (VW)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (mem_ctl.cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .re_i    (mem_ctl.cell_re),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  // scratch copy used within one rotate
  srre_ram #(
    .DEPTH (DEPTH),
    .DW    (VW)
  ) u_scr_ram (
    .clk_i   (clk_i),
    .we_i    (mem_ctl.scr_we),
    .waddr_i (scr_waddr),
    .wdata_i (scr_wdata),
    .re_i    (mem_ctl.scr_re),
    .raddr_i (scr_raddr),
    .rdata_o (scr_rdata)
  );

  // output register: frees the sequencer while the sink stalls
  logic          out_valid_q, out_valid_d;
  logic [VW-1:0] out_value_q;
  logic          out_err_q;
  logic          out_load;

  assign res_ready   = !out_valid_q || m_axis_tready_i;
  assign out_load    = res_valid && res_ready;
  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= res_value;
      out_err_q   <= res_err;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(16 - VW)'(0), out_value_q};
  assign m_axis_tuser_o  = out_err_q;

endmodule

/* src/srre_checker.sv */
// Port-level assertions for the square region rotate engine, bound to the top level.
`include "assert_macros.svh"

module srre_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [0:0]  m_axis_tuser_o
);

  // a stalled result keeps its payload
  `SRRE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result changed")

  // an ignored command never carries a cell value
  `SRRE_ASSERT_IMPLIES(a_err_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tdata_o == 16'd0, "range error with non-zero value")

  // commands are taken one at a time
  `SRRE_ASSERT_NEXT(a_one_cmd, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "request taken while busy")

endmodule

bind square_region_rotate_engine_core srre_checker u_srre_checker (.*);

/* sim/tb_square_region_rotate_engine_core.sv */
// Testbench for the square region rotate engine: requests checked against a predictor.
`timescale 1ns / 100ps

module tb_square_region_rotate_engine_core;

  localparam int MAX_SIZE = 64;
  localparam int MAX_CELLS = MAX_SIZE * MAX_SIZE;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;  // not decoded by the block

  // One result as it should leave the master side.
  typedef struct packed {
    logic [srre_pkg::VAL_W-1:0] value;
    logic                       range_err;
  } srre_result_t;

  // Keeps its own copy of the matrix and size, works out the result of every
  // accepted request and compares results in order.
  class srre_scoreboard;
    logic [srre_pkg::VAL_W-1:0] matrix_q [MAX_CELLS];
    logic [srre_pkg::VAL_W-1:0] turn_buf [MAX_CELLS];
    logic [srre_pkg::SIZE_W-1:0] size_reg;
    srre_result_t expected_results [$];
    int mismatches;

    function new();
      foreach (matrix_q[k]) matrix_q[k] = '0;
      size_reg = 7'd64;
      mismatches = 0;
    endfunction

    function void set_size(logic [srre_pkg::SIZE_W-1:0] v);
      size_reg = v;
    endfunction

    // Size in use, clamped to 1..MAX_SIZE.
    function int eff_size();
      if (size_reg < 1) return 1;
      if (size_reg > MAX_SIZE) return MAX_SIZE;
      return int'(size_reg);
    endfunction

    function void note_command(logic [1:0] cmd, logic [5:0] row, logic [5:0] col,
                               logic [4:0] rad, logic ccw);
      int n, x, y, r, dr, dc;
      srre_result_t res;
      n = eff_size();
      x = row;
      y = col;
      r = rad;
      res = '0;
      case (cmd)
        srre_pkg::CMD_FILL: begin
          for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
              matrix_q[i * MAX_SIZE + j] = srre_pkg::VAL_W'(i * n + j + 1);
        end
        srre_pkg::CMD_ROTATE: begin
          if (x - r < 0 || x + r >= n || y - r < 0 || y + r >= n) begin
            res.range_err = 1'b1;
          end else begin
            // place each cell at its turned position, then copy the square back
            for (int i = x - r; i <= x + r; i++) begin
              for (int j = y - r; j <= y + r; j++) begin
                if (!ccw) begin
                  dr = x - y + j;
                  dc = x + y - i;
                end else begin
                  dr = x + y - j;
                  dc = i + y - x;
                end
                turn_buf[dr * MAX_SIZE + dc] = matrix_q[i * MAX_SIZE + j];
              end
            end
            for (int i = x - r; i <= x + r; i++)
              for (int j = y - r; j <= y + r; j++)
                matrix_q[i * MAX_SIZE + j] = turn_buf[i * MAX_SIZE + j];
          end
        end
        srre_pkg::CMD_READ: begin
          if (x >= n || y >= n) res.range_err = 1'b1;
          else res.value = matrix_q[x * MAX_SIZE + y];
        end
        default: ;
      endcase
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [15:0] data, logic [0:0] user);
      srre_result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none pending: value %0d err %0d", $time,
                   data[srre_pkg::VAL_W-1:0], user[0]);
        return;
      end
      want = expected_results.pop_front();
      if (data !== {3'b000, want.value} || user[0] !== want.range_err) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: value exp %0d got %0d, err exp %0d got %0d", $time,
                   want.value, data, want.range_err, user[0]);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function bit failed();
      return mismatches > 0 || expected_results.size() > 0;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [6:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tready = 1'b0;
  wire         cfg_ready_o;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [15:0] m_axis_tdata_o;
  wire  [0:0]  m_axis_tuser_o;

  srre_scoreboard sb = new();
  bit quiet_run = 1'b0;  // no idling on either side in the closing phase
  int sink_hold = 0;

  always #10 clk_i = ~clk_i;

  square_region_rotate_engine_core #(
    .MAX_SIZE(MAX_SIZE)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // Result sink: check on handshake, then decide the next cycle's ready.
  // Stalls start at random and come in bursts of random length.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready) sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
        sink_hold = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // One request on the slave side. Valid is left high on return, so a
  // back-to-back request never drops it; an idle gap or a drain lowers it.
  task automatic issue_command(input int cmd, input int row, input int col,
                               input int rad, input int ccw);
    if (!quiet_run && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= 2'(cmd);
    s_axis_tdata  <= {6'b0, 1'(ccw), 5'(rad), 6'(col), 6'(row)};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_command(2'(cmd), 6'(row), 6'(col), 5'(rad), 1'(ccw));
  endtask

  // Stop sending and let every outstanding result come back, plus a margin.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // matrix_size is only changed with the engine idle.
  task automatic write_size(input logic [6:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    sb.set_size(v);
  endtask

  // A phase: optional fill, then mostly legal rotates and reads, occasional fills,
  // and some out-of-range requests and unknown commands carrying random fields.
  task automatic run_random_phase(input logic [6:0] size_cfg, input int count);
    int n, pick, r, row, col;
    write_size(size_cfg);
    n = sb.eff_size();
    if ($urandom_range(0, 1))
      issue_command(srre_pkg::CMD_FILL, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 31), $urandom_range(0, 1));
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        issue_command(srre_pkg::CMD_FILL, $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 31), $urandom_range(0, 1));
      end else if (pick < 50) begin
        r = $urandom_range(0, (n - 1) / 2);
        row = $urandom_range(r, n - 1 - r);
        col = $urandom_range(r, n - 1 - r);
        issue_command(srre_pkg::CMD_ROTATE, row, col, r, $urandom_range(0, 1));
      end else if (pick < 85) begin
        issue_command(srre_pkg::CMD_READ, $urandom_range(0, n - 1),
                      $urandom_range(0, n - 1),
                      $urandom_range(0, 31), $urandom_range(0, 1));
      end else if (pick < 95) begin
        // mostly off the matrix; an occasional legal hit is fine
        issue_command($urandom_range(0, 1) ? srre_pkg::CMD_ROTATE : srre_pkg::CMD_READ,
                      $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 31), $urandom_range(0, 1));
      end else begin
        issue_command(CMD_UNKNOWN, $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 31), $urandom_range(0, 1));
      end
    end
  endtask

  initial begin
    int sel;
    logic [6:0] size_cfg;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset size 64: a full fill first, so no cell is ever read unwritten.
    issue_command(srre_pkg::CMD_FILL, 0, 0, 0, 0);
    issue_command(srre_pkg::CMD_READ, 0, 0, 0, 0);
    issue_command(srre_pkg::CMD_READ, 63, 63, 31, 1);
    issue_command(srre_pkg::CMD_READ, 0, 63, 0, 0);
    issue_command(srre_pkg::CMD_ROTATE, 31, 31, 31, 0);   // 63x63 square at the top-left, clockwise
    issue_command(srre_pkg::CMD_READ, 0, 0, 0, 0);
    issue_command(srre_pkg::CMD_READ, 63, 0, 0, 0);
    issue_command(srre_pkg::CMD_ROTATE, 32, 32, 31, 1);   // largest square, anticlockwise
    issue_command(srre_pkg::CMD_ROTATE, 63, 63, 0, 0);    // radius zero
    issue_command(srre_pkg::CMD_READ, 63, 63, 0, 0);
    issue_command(srre_pkg::CMD_ROTATE, 0, 0, 1, 0);      // region off the top-left
    issue_command(srre_pkg::CMD_ROTATE, 63, 63, 31, 1);   // region off the bottom-right
    issue_command(CMD_UNKNOWN, 63, 63, 31, 1);
    issue_command(srre_pkg::CMD_ROTATE, 5, 9, 3, 1);
    issue_command(srre_pkg::CMD_READ, 7, 10, 0, 0);

    // Size register zero behaves as one.
    write_size(7'd0);
    issue_command(srre_pkg::CMD_FILL, 63, 63, 31, 1);
    issue_command(srre_pkg::CMD_READ, 0, 0, 0, 0);
    issue_command(srre_pkg::CMD_READ, 0, 1, 0, 0);        // cell off the matrix
    issue_command(srre_pkg::CMD_ROTATE, 0, 0, 0, 1);
    issue_command(srre_pkg::CMD_ROTATE, 0, 0, 1, 0);
    issue_command(srre_pkg::CMD_READ, 1, 0, 0, 0);

    // All ones clamps to 64; cells outside the small fill must have kept their values.
    write_size(7'd127);
    issue_command(srre_pkg::CMD_READ, 63, 63, 0, 0);
    issue_command(srre_pkg::CMD_READ, 2, 0, 0, 0);
    issue_command(srre_pkg::CMD_ROTATE, 40, 20, 5, 1);
    issue_command(srre_pkg::CMD_READ, 45, 20, 0, 0);

    for (int ph = 0; ph < 8; ph++) begin
      sel = $urandom_range(0, 15);
      if (ph == 1 || sel == 3) size_cfg = 7'd64;
      else if (sel == 0) size_cfg = 7'd0;
      else if (sel == 1) size_cfg = 7'd1;
      else if (sel == 2) size_cfg = 7'($urandom_range(65, 127));
      else size_cfg = 7'($urandom_range(2, 16));
      quiet_run = (ph == 7);
      run_random_phase(size_cfg, 12);
    end

    wait_idle();
    repeat (16) @(posedge clk_i);
    if (!sb.failed()) begin
      $display("[square_region_rotate_engine_core] OK");
    end else begin
      $display("[square_region_rotate_engine_core] ERROR");
    end
    $finish;
  end

  // Watchdog: flags an error and stops the run if it hangs.
  initial begin
    #(64'd100_000_000);
    $display("[square_region_rotate_engine_core] ERROR");
    $finish;
  end

endmodule
